// ----- hw/rtl/cfsm_pkg.sv -----
`default_nettype none

package cfsm_pkg;

  // Supervisor modes, one-hot
  typedef enum logic [7:0] {
    ModeInit   = 8'b0000_0001,
    ModeRdyChk = 8'b0000_0010,
    ModeReady  = 8'b0000_0100,
    ModeRunChk = 8'b0000_1000,
    ModeRun    = 8'b0001_0000,
    ModeRecF   = 8'b0010_0000,
    ModeFault  = 8'b0100_0000,
    ModeLatch  = 8'b1000_0000
  } mode_e;

  // Mode codes as reported on the result word
  localparam logic [2:0] MODE_INIT    = 3'd0;
  localparam logic [2:0] MODE_RDYCHK  = 3'd1;
  localparam logic [2:0] MODE_READY   = 3'd2;
  localparam logic [2:0] MODE_RUNCHK  = 3'd3;
  localparam logic [2:0] MODE_RUN     = 3'd4;
  localparam logic [2:0] MODE_RECF    = 3'd5;
  localparam logic [2:0] MODE_FAULT   = 3'd6;
  localparam logic [2:0] MODE_LATCH   = 3'd7;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_FATAL_MASK   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RECOV_MASK   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_MASK = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BUS_OFF_MASK = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LINK_TO_MASK = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RDY_CHK_TICKS = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_RUN_CHK_TICKS = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_LATCH_TICKS  = 3'd7;

  // Reset values of the tick limits
  localparam int unsigned ReadyCheckTicksRst = 70;
  localparam int unsigned RunCheckTicksRst   = 30;
  localparam int unsigned LatchHoldTicksRst  = 5000;

  // Result word flags
  typedef struct packed {
    logic ready_flag;
    logic run_flag;
    logic regulator_init;
    logic pwm_enable;
    logic derate_tick;
    logic latch_release;
    logic clear_fatal_errors;
  } flags_t;

  function automatic logic [2:0] mode_code(input mode_e m);
    logic [2:0] c;
    case (m)
      ModeInit:   c = MODE_INIT;
      ModeRdyChk: c = MODE_RDYCHK;
      ModeReady:  c = MODE_READY;
      ModeRunChk: c = MODE_RUNCHK;
      ModeRun:    c = MODE_RUN;
      ModeRecF:   c = MODE_RECF;
      ModeFault:  c = MODE_FAULT;
      default:    c = MODE_LATCH;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cfsm_in_if.sv -----
`default_nettype none

interface cfsm_in_if #(
  parameter int unsigned ERROR_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic                   ignition_on;
  logic                   enable_request;
  logic [ERROR_WIDTH-1:0] error_status;
  logic                   battery_disconnected;

  modport source (output valid, ignition_on, enable_request, error_status,
                  battery_disconnected, input ready);
  modport sink   (input valid, ignition_on, enable_request, error_status,
                  battery_disconnected, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cfsm_out_if.sv -----
`default_nettype none

interface cfsm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       ready_flag;
  logic       run_flag;
  logic       regulator_init;
  logic       pwm_enable;
  logic       derate_tick;
  logic       latch_release;
  logic       clear_fatal_errors;

  modport source (output valid, mode, ready_flag, run_flag, regulator_init,
                  pwm_enable, derate_tick, latch_release, clear_fatal_errors,
                  input ready);
  modport sink   (input valid, mode, ready_flag, run_flag, regulator_init,
                  pwm_enable, derate_tick, latch_release, clear_fatal_errors,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cfsm_cfg_regs.sv -----
`default_nettype none

module cfsm_cfg_regs #(
  parameter int unsigned ERROR_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        we_i,
  input  wire logic [cfsm_pkg::CfgIdxW-1:0] idx_i,
  input  wire logic [DATA_WIDTH-1:0]       wdata_i,
  output logic [ERROR_WIDTH-1:0]           fatal_mask_o,
  output logic [ERROR_WIDTH-1:0]           recov_mask_o,
  output logic [ERROR_WIDTH-1:0]           release_mask_o,
  output logic [ERROR_WIDTH-1:0]           bus_off_mask_o,
  output logic [ERROR_WIDTH-1:0]           link_to_mask_o,
  output logic [COUNT_WIDTH-1:0]           rdy_chk_ticks_o,
  output logic [COUNT_WIDTH-1:0]           run_chk_ticks_o,
  output logic [COUNT_WIDTH-1:0]           latch_ticks_o
);

  logic [ERROR_WIDTH-1:0] err_val;
  logic [COUNT_WIDTH-1:0] cnt_val;

  assign err_val = wdata_i[ERROR_WIDTH-1:0];
  assign cnt_val = wdata_i[COUNT_WIDTH-1:0];

  // register file, written one register per write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fatal_mask_o    <= '0;
      recov_mask_o    <= '0;
      release_mask_o  <= '0;
      bus_off_mask_o  <= '0;
      link_to_mask_o  <= '0;
      rdy_chk_ticks_o <= COUNT_WIDTH'(cfsm_pkg::ReadyCheckTicksRst);
      run_chk_ticks_o <= COUNT_WIDTH'(cfsm_pkg::RunCheckTicksRst);
      latch_ticks_o   <= COUNT_WIDTH'(cfsm_pkg::LatchHoldTicksRst);
    end else if (we_i) begin
      case (idx_i)
        cfsm_pkg::CFG_FATAL_MASK:    fatal_mask_o    <= err_val;
        cfsm_pkg::CFG_RECOV_MASK:    recov_mask_o    <= err_val;
        cfsm_pkg::CFG_RELEASE_MASK:  release_mask_o  <= err_val;
        cfsm_pkg::CFG_BUS_OFF_MASK:  bus_off_mask_o  <= err_val;
        cfsm_pkg::CFG_LINK_TO_MASK:  link_to_mask_o  <= err_val;
        cfsm_pkg::CFG_RDY_CHK_TICKS: rdy_chk_ticks_o <= cnt_val;
        cfsm_pkg::CFG_RUN_CHK_TICKS: run_chk_ticks_o <= cnt_val;
        cfsm_pkg::CFG_LATCH_TICKS:   latch_ticks_o   <= cnt_val;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cfsm_step.sv -----
`default_nettype none

module cfsm_step #(
  parameter int unsigned ERROR_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire cfsm_pkg::mode_e       mode_i,
  input  wire logic [COUNT_WIDTH-1:0] check_cnt_i,
  input  wire logic [COUNT_WIDTH-1:0] latch_cnt_i,
  input  wire logic                   ign_i,
  input  wire logic                   en_i,
  input  wire logic [ERROR_WIDTH-1:0] err_i,
  input  wire logic                   batt_i,
  input  wire logic [ERROR_WIDTH-1:0] fatal_mask_i,
  input  wire logic [ERROR_WIDTH-1:0] recov_mask_i,
  input  wire logic [ERROR_WIDTH-1:0] release_mask_i,
  input  wire logic [ERROR_WIDTH-1:0] bus_off_mask_i,
  input  wire logic [ERROR_WIDTH-1:0] link_to_mask_i,
  input  wire logic [COUNT_WIDTH-1:0] rdy_chk_ticks_i,
  input  wire logic [COUNT_WIDTH-1:0] run_chk_ticks_i,
  input  wire logic [COUNT_WIDTH-1:0] latch_ticks_i,
  output cfsm_pkg::mode_e             mode_o,
  output logic [COUNT_WIDTH-1:0]      check_cnt_o,
  output logic [COUNT_WIDTH-1:0]      latch_cnt_o,
  output cfsm_pkg::flags_t            flags_o
);

  logic                   fatal;
  logic                   common;
  logic                   recov;
  logic                   hold;
  logic [COUNT_WIDTH-1:0] check_inc;

  // error classification
  assign fatal  = |(err_i & fatal_mask_i);
  assign common = ((err_i & bus_off_mask_i) == bus_off_mask_i)
               || ((err_i & link_to_mask_i) == link_to_mask_i)
               || batt_i;
  assign recov  = (|(err_i & recov_mask_i)) || common;
  assign hold   = (|(err_i & release_mask_i)) || common;

  // saturating check counter increment
  assign check_inc = (check_cnt_i == '1) ? check_cnt_i : check_cnt_i + COUNT_WIDTH'(1);

  // mode transitions and flags for one tick
  always_comb begin
    mode_o      = mode_i;
    check_cnt_o = check_cnt_i;
    latch_cnt_o = latch_cnt_i;
    flags_o     = '0;
    case (mode_i)
      cfsm_pkg::ModeInit: begin
        check_cnt_o = '0;
        mode_o      = cfsm_pkg::ModeRdyChk;
      end
      cfsm_pkg::ModeRdyChk: begin
        if (check_cnt_i >= rdy_chk_ticks_i) begin
          if (fatal) begin
            mode_o = cfsm_pkg::ModeFault;
          end else if (!recov) begin
            flags_o.ready_flag = 1'b1;
            mode_o             = cfsm_pkg::ModeReady;
          end
        end else begin
          check_cnt_o = check_inc;
        end
        // ignition off wins, ready flag stays as written
        if (!ign_i) begin
          latch_cnt_o = '0;
          mode_o      = cfsm_pkg::ModeLatch;
        end
      end
      cfsm_pkg::ModeReady: begin
        flags_o.ready_flag = 1'b1;
        if (!ign_i) begin
          flags_o.ready_flag = 1'b0;
          latch_cnt_o        = '0;
          mode_o             = cfsm_pkg::ModeLatch;
        end else if (fatal) begin
          flags_o.ready_flag = 1'b0;
          mode_o             = cfsm_pkg::ModeFault;
        end else if (recov) begin
          flags_o.ready_flag = 1'b0;
          mode_o             = cfsm_pkg::ModeInit;
        end else if (en_i) begin
          flags_o.regulator_init = 1'b1;
          check_cnt_o            = '0;
          mode_o                 = cfsm_pkg::ModeRunChk;
        end
      end
      cfsm_pkg::ModeRunChk: begin
        flags_o.ready_flag = 1'b1;
        if (check_cnt_i >= run_chk_ticks_i) begin
          if (fatal) begin
            flags_o.ready_flag = 1'b0;
            mode_o             = cfsm_pkg::ModeFault;
          end else if (recov) begin
            flags_o.ready_flag = 1'b0;
            mode_o             = cfsm_pkg::ModeRecF;
          end else begin
            flags_o.run_flag   = 1'b1;
            flags_o.pwm_enable = 1'b1;
            mode_o             = cfsm_pkg::ModeRun;
          end
        end else begin
          check_cnt_o = check_inc;
        end
        // ignition off or enable drop overrides the check outcome, enable drop keeps the flags
        if (!ign_i) begin
          flags_o.ready_flag = 1'b0;
          latch_cnt_o        = '0;
          mode_o             = cfsm_pkg::ModeLatch;
        end else if (!en_i) begin
          mode_o = cfsm_pkg::ModeReady;
        end
      end
      cfsm_pkg::ModeRun: begin
        flags_o.ready_flag  = 1'b1;
        flags_o.run_flag    = 1'b1;
        flags_o.derate_tick = 1'b1;
        if (!ign_i) begin
          flags_o.ready_flag = 1'b0;
          flags_o.run_flag   = 1'b0;
          latch_cnt_o        = '0;
          mode_o             = cfsm_pkg::ModeLatch;
        end else if (fatal) begin
          flags_o.ready_flag = 1'b0;
          flags_o.run_flag   = 1'b0;
          mode_o             = cfsm_pkg::ModeFault;
        end else if (recov) begin
          flags_o.ready_flag = 1'b0;
          flags_o.run_flag   = 1'b0;
          mode_o             = cfsm_pkg::ModeRecF;
        end else if (!en_i) begin
          flags_o.run_flag = 1'b0;
          mode_o           = cfsm_pkg::ModeReady;
        end
      end
      cfsm_pkg::ModeRecF: begin
        if (!ign_i) begin
          latch_cnt_o = '0;
          mode_o      = cfsm_pkg::ModeLatch;
        end else if (!hold) begin
          mode_o = cfsm_pkg::ModeInit;
        end
      end
      cfsm_pkg::ModeFault: begin
        if (!ign_i) begin
          latch_cnt_o = '0;
          mode_o      = cfsm_pkg::ModeLatch;
        end
      end
      default: begin
        // power latch
        if (latch_cnt_i >= latch_ticks_i) begin
          flags_o.latch_release = 1'b1;
        end else begin
          latch_cnt_o = latch_cnt_i + COUNT_WIDTH'(1);
          if (ign_i) begin
            flags_o.clear_fatal_errors = 1'b1;
            mode_o                     = cfsm_pkg::ModeInit;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/converter_supervisor_fsm_unit.sv -----
// Channel   Dir  Payload                                          Handshake
// in_i      in   ignition_on, enable_request, error_status,      valid/ready
//                battery_disconnected
// out_o     out  mode, ready_flag, run_flag, regulator_init,      valid/ready
//                pwm_enable, derate_tick, latch_release,
//                clear_fatal_errors
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i                 write enable
//
// One word per cycle sustained while out_o.ready stays high. An accepted word is
// held in the input register, the mode update runs between it and the result
// register, which then presents the result word. Reset clears mode to init, both
// counters and the pipeline valids. A stalled result holds; the input register
// fills behind it and in_i.ready drops only when both stages are full.
`default_nettype none

module converter_supervisor_fsm_unit #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned ERROR_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  cfsm_in_if.sink                                  in_i,
  cfsm_out_if.source                               out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [cfsm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [((ERROR_WIDTH > COUNT_WIDTH) ?
                      ERROR_WIDTH : COUNT_WIDTH)-1:0] cfg_wdata_i
);

  localparam int unsigned DataWidth =
    (ERROR_WIDTH > COUNT_WIDTH) ? ERROR_WIDTH : COUNT_WIDTH;

  logic [ERROR_WIDTH-1:0] fatal_mask, recov_mask, release_mask;
  logic [ERROR_WIDTH-1:0] bus_off_mask, link_to_mask;
  logic [COUNT_WIDTH-1:0] rdy_chk_ticks, run_chk_ticks, latch_ticks;

  // input register
  logic                   in_vld_q;
  logic                   ign_q, en_q, batt_q;
  logic [ERROR_WIDTH-1:0] err_q;

  // supervisor state
  cfsm_pkg::mode_e        mode_q, mode_d;
  logic [COUNT_WIDTH-1:0] check_cnt_q, check_cnt_d;
  logic [COUNT_WIDTH-1:0] latch_cnt_q, latch_cnt_d;

  // result register
  logic                   out_vld_q;
  logic [2:0]             res_mode_q;
  cfsm_pkg::flags_t       res_flags_q, flags_d;

  logic out_free;
  logic advance;
  logic in_fire;

  assign out_free = !out_vld_q || out_o.ready;
  assign advance  = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;

  cfsm_cfg_regs #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH),
    .DATA_WIDTH  (DataWidth)
  ) u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .we_i            (cfg_we_i),
    .idx_i           (cfg_idx_i),
    .wdata_i         (cfg_wdata_i),
    .fatal_mask_o    (fatal_mask),
    .recov_mask_o    (recov_mask),
    .release_mask_o  (release_mask),
    .bus_off_mask_o  (bus_off_mask),
    .link_to_mask_o  (link_to_mask),
    .rdy_chk_ticks_o (rdy_chk_ticks),
    .run_chk_ticks_o (run_chk_ticks),
    .latch_ticks_o   (latch_ticks)
  );

  cfsm_step #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .mode_i          (mode_q),
    .check_cnt_i     (check_cnt_q),
    .latch_cnt_i     (latch_cnt_q),
    .ign_i           (ign_q),
    .en_i            (en_q),
    .err_i           (err_q),
    .batt_i          (batt_q),
    .fatal_mask_i    (fatal_mask),
    .recov_mask_i    (recov_mask),
    .release_mask_i  (release_mask),
    .bus_off_mask_i  (bus_off_mask),
    .link_to_mask_i  (link_to_mask),
    .rdy_chk_ticks_i (rdy_chk_ticks),
    .run_chk_ticks_i (run_chk_ticks),
    .latch_ticks_i   (latch_ticks),
    .mode_o          (mode_d),
    .check_cnt_o     (check_cnt_d),
    .latch_cnt_o     (latch_cnt_d),
    .flags_o         (flags_d)
  );

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ign_q  <= in_i.ignition_on;
      en_q   <= in_i.enable_request;
      err_q  <= in_i.error_status;
      batt_q <= in_i.battery_disconnected;
    end
  end

  // state update, once per word moved to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= cfsm_pkg::ModeInit;
      check_cnt_q <= '0;
      latch_cnt_q <= '0;
    end else if (advance) begin
      mode_q      <= mode_d;
      check_cnt_q <= check_cnt_d;
      latch_cnt_q <= latch_cnt_d;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_mode_q  <= cfsm_pkg::mode_code(mode_d);
      res_flags_q <= flags_d;
    end
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.mode               = res_mode_q;
  assign out_o.ready_flag         = res_flags_q.ready_flag;
  assign out_o.run_flag           = res_flags_q.run_flag;
  assign out_o.regulator_init     = res_flags_q.regulator_init;
  assign out_o.pwm_enable         = res_flags_q.pwm_enable;
  assign out_o.derate_tick        = res_flags_q.derate_tick;
  assign out_o.latch_release      = res_flags_q.latch_release;
  assign out_o.clear_fatal_errors = res_flags_q.clear_fatal_errors;

endmodule

`default_nettype wire

// ----- hw/rtl/cfsm_checker.sv -----
`default_nettype none

module cfsm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] mode_i,
  input wire logic       ready_flag_i,
  input wire logic       run_flag_i,
  input wire logic       regulator_init_i,
  input wire logic       pwm_enable_i,
  input wire logic       latch_release_i,
  input wire logic       clear_fatal_errors_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mode_i)
      && $stable(run_flag_i))
    else $error("result word changed while stalled");

  // run flag only on a tick that ends in run, ready or power latch
  a_run_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (run_flag_i || pwm_enable_i) |->
      run_flag_i && (mode_i == cfsm_pkg::MODE_RUN || mode_i == cfsm_pkg::MODE_READY
      || mode_i == cfsm_pkg::MODE_LATCH))
    else $error("run flag or pwm enable outside run");

  // clearing fatal errors only on the return from power latch to init
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clear_fatal_errors_i |->
      mode_i == cfsm_pkg::MODE_INIT && !latch_release_i && !ready_flag_i)
    else $error("fatal clear outside latch exit");

  // regulator init goes with the step from ready to run-check
  a_reg_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && regulator_init_i |->
      mode_i == cfsm_pkg::MODE_RUNCHK && ready_flag_i && !pwm_enable_i)
    else $error("regulator init without run-check entry");

endmodule

bind converter_supervisor_fsm_unit cfsm_checker u_cfsm_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .mode_i               (out_o.mode),
  .ready_flag_i         (out_o.ready_flag),
  .run_flag_i           (out_o.run_flag),
  .regulator_init_i     (out_o.regulator_init),
  .pwm_enable_i         (out_o.pwm_enable),
  .latch_release_i      (out_o.latch_release),
  .clear_fatal_errors_i (out_o.clear_fatal_errors)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_NOTES   = 40;

  // one input word and one result word
  typedef struct packed {
    logic        ign;
    logic        en;
    logic [31:0] err;
    logic        batt;
  } tick_t;

  typedef struct packed {
    logic [2:0]       mode;
    cfsm_pkg::flags_t flags;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [cfsm_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [31:0]                  cfg_wdata = '0;

  cfsm_in_if #(.ERROR_WIDTH(32)) in_ch ();
  cfsm_out_if                    out_ch ();

  converter_supervisor_fsm_unit #(
    .COUNT_WIDTH(16),
    .ERROR_WIDTH(32)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // supervisor model state and register copies
  logic [2:0]  sup_mode = cfsm_pkg::MODE_INIT;
  logic [15:0] chk_cnt = '0;
  logic [15:0] lat_cnt = '0;
  logic [31:0] fatal_m = '0, recov_m = '0, release_m = '0, busoff_m = '0, linkto_m = '0;
  logic [15:0] rdy_ticks = 16'(cfsm_pkg::ReadyCheckTicksRst);
  logic [15:0] run_ticks = 16'(cfsm_pkg::RunCheckTicksRst);
  logic [15:0] hold_ticks = 16'(cfsm_pkg::LatchHoldTicksRst);

  tick_t   pending_ticks[$];
  status_t status_due[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mode_seen[8];
  logic gen_ign = 1'b1;
  logic gen_en = 1'b0;

  string flag_name[7] = '{"ready_flag", "run_flag", "regulator_init", "pwm_enable",
                          "derate_tick", "latch_release", "clear_fatal_errors"};

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_NOTES) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // recoverable test; also used as the release test with release_m
  function automatic logic recov_hit(logic [31:0] err, logic [31:0] m, logic batt);
    return ((err & m) != 32'd0) || ((err & busoff_m) == busoff_m) ||
           ((err & linkto_m) == linkto_m) || batt;
  endfunction

  function automatic void bump_check();
    if (chk_cnt != 16'hFFFF) chk_cnt = chk_cnt + 16'd1;
  endfunction

  // advance the supervisor by one tick and return the status it reports
  function automatic status_t step_supervisor(tick_t t);
    status_t r;
    logic    fatal;
    logic    recov;
    r = '0;
    fatal = (t.err & fatal_m) != 32'd0;
    recov = recov_hit(t.err, recov_m, t.batt);
    case (sup_mode)
      cfsm_pkg::MODE_INIT: begin
        chk_cnt = '0;
        sup_mode = cfsm_pkg::MODE_RDYCHK;
      end
      cfsm_pkg::MODE_RDYCHK: begin
        if (chk_cnt >= rdy_ticks) begin
          if (fatal) begin
            sup_mode = cfsm_pkg::MODE_FAULT;
          end else if (!recov) begin
            r.flags.ready_flag = 1'b1;
            sup_mode = cfsm_pkg::MODE_READY;
          end
        end else begin
          bump_check();
        end
        // ignition off wins over the mode, the flag stays as written
        if (!t.ign) begin
          lat_cnt = '0;
          sup_mode = cfsm_pkg::MODE_LATCH;
        end
      end
      cfsm_pkg::MODE_READY: begin
        r.flags.ready_flag = 1'b1;
        if (!t.ign) begin
          r.flags.ready_flag = 1'b0;
          lat_cnt = '0;
          sup_mode = cfsm_pkg::MODE_LATCH;
        end else if (fatal) begin
          r.flags.ready_flag = 1'b0;
          sup_mode = cfsm_pkg::MODE_FAULT;
        end else if (recov) begin
          r.flags.ready_flag = 1'b0;
          sup_mode = cfsm_pkg::MODE_INIT;
        end else if (t.en) begin
          r.flags.regulator_init = 1'b1;
          chk_cnt = '0;
          sup_mode = cfsm_pkg::MODE_RUNCHK;
        end
      end
      cfsm_pkg::MODE_RUNCHK: begin
        r.flags.ready_flag = 1'b1;
        if (chk_cnt >= run_ticks) begin
          if (fatal) begin
            r.flags.ready_flag = 1'b0;
            sup_mode = cfsm_pkg::MODE_FAULT;
          end else if (recov) begin
            r.flags.ready_flag = 1'b0;
            sup_mode = cfsm_pkg::MODE_RECF;
          end else begin
            r.flags.run_flag = 1'b1;
            r.flags.pwm_enable = 1'b1;
            sup_mode = cfsm_pkg::MODE_RUN;
          end
        end else begin
          bump_check();
        end
        // ignition off or enable drop overrides the check outcome; enable drop keeps its flags
        if (!t.ign) begin
          r.flags.ready_flag = 1'b0;
          lat_cnt = '0;
          sup_mode = cfsm_pkg::MODE_LATCH;
        end else if (!t.en) begin
          sup_mode = cfsm_pkg::MODE_READY;
        end
      end
      cfsm_pkg::MODE_RUN: begin
        r.flags.ready_flag = 1'b1;
        r.flags.run_flag = 1'b1;
        r.flags.derate_tick = 1'b1;
        if (!t.ign) begin
          r.flags.ready_flag = 1'b0;
          r.flags.run_flag = 1'b0;
          lat_cnt = '0;
          sup_mode = cfsm_pkg::MODE_LATCH;
        end else if (fatal) begin
          r.flags.ready_flag = 1'b0;
          r.flags.run_flag = 1'b0;
          sup_mode = cfsm_pkg::MODE_FAULT;
        end else if (recov) begin
          r.flags.ready_flag = 1'b0;
          r.flags.run_flag = 1'b0;
          sup_mode = cfsm_pkg::MODE_RECF;
        end else if (!t.en) begin
          r.flags.run_flag = 1'b0;
          sup_mode = cfsm_pkg::MODE_READY;
        end
      end
      cfsm_pkg::MODE_RECF: begin
        if (!t.ign) begin
          lat_cnt = '0;
          sup_mode = cfsm_pkg::MODE_LATCH;
        end else if (!recov_hit(t.err, release_m, t.batt)) begin
          sup_mode = cfsm_pkg::MODE_INIT;
        end
      end
      cfsm_pkg::MODE_FAULT: begin
        if (!t.ign) begin
          lat_cnt = '0;
          sup_mode = cfsm_pkg::MODE_LATCH;
        end
      end
      default: begin
        if (lat_cnt >= hold_ticks) begin
          r.flags.latch_release = 1'b1;
        end else begin
          lat_cnt = lat_cnt + 16'd1;
          if (t.ign) begin
            r.flags.clear_fatal_errors = 1'b1;
            sup_mode = cfsm_pkg::MODE_INIT;
          end
        end
      end
    endcase
    r.mode = sup_mode;
    return r;
  endfunction

  function automatic logic [31:0] sparse_bits(int unsigned n);
    logic [31:0] w;
    w = '0;
    repeat (n) w |= 32'd1 << $urandom_range(0, 31);
    return w;
  endfunction

  // register write, one per cycle, model copy updated alongside
  task automatic write_reg(input logic [cfsm_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      cfsm_pkg::CFG_FATAL_MASK:    fatal_m = val;
      cfsm_pkg::CFG_RECOV_MASK:    recov_m = val;
      cfsm_pkg::CFG_RELEASE_MASK:  release_m = val;
      cfsm_pkg::CFG_BUS_OFF_MASK:  busoff_m = val;
      cfsm_pkg::CFG_LINK_TO_MASK:  linkto_m = val;
      cfsm_pkg::CFG_RDY_CHK_TICKS: rdy_ticks = val[15:0];
      cfsm_pkg::CFG_RUN_CHK_TICKS: run_ticks = val[15:0];
      cfsm_pkg::CFG_LATCH_TICKS:   hold_ticks = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] fm, rm, relm, bm, lm,
                           input logic [15:0] rt, nt, ht);
    write_reg(cfsm_pkg::CFG_FATAL_MASK, fm);
    write_reg(cfsm_pkg::CFG_RECOV_MASK, rm);
    write_reg(cfsm_pkg::CFG_RELEASE_MASK, relm);
    write_reg(cfsm_pkg::CFG_BUS_OFF_MASK, bm);
    write_reg(cfsm_pkg::CFG_LINK_TO_MASK, lm);
    write_reg(cfsm_pkg::CFG_RDY_CHK_TICKS, {16'd0, rt});
    write_reg(cfsm_pkg::CFG_RUN_CHK_TICKS, {16'd0, nt});
    write_reg(cfsm_pkg::CFG_LATCH_TICKS, {16'd0, ht});
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  // per-phase register set; some phases pin the extremes
  task automatic setup_phase(input int unsigned p);
    logic [31:0] fm, rm, relm, bm, lm;
    logic [15:0] rt, nt, ht;
    fm = sparse_bits(2);
    rm = sparse_bits(3);
    relm = (rm & $urandom()) | sparse_bits(1);
    bm = sparse_bits(2);
    lm = sparse_bits(2);
    rt = 16'($urandom_range(0, 6));
    nt = 16'($urandom_range(0, 6));
    ht = 16'($urandom_range(1, 10));
    case (p)
      2: begin
        rt = '0;
        nt = '0;
      end
      3: begin
        fm = '1;
        rm = '1;
        relm = '1;
        bm = '1;
        lm = '1;
      end
      5: begin
        fm = '0;
        rm = '0;
        relm = '0;
        bm = '0;
        lm = '0;
        ht = '0;
      end
      6: begin
        nt = 16'hFFFF;
        ht = 16'hFFFF;
      end
      7: rt = 16'hFFFF;
      default: ;
    endcase
    // a finished latch only leaves once the hold is raised above its count
    if (p != 5 && sup_mode == cfsm_pkg::MODE_LATCH && lat_cnt >= ht)
      ht = lat_cnt + 16'd1 + 16'($urandom_range(0, 5));
    write_all(fm, rm, relm, bm, lm, rt, nt, ht);
  endtask

  task automatic add_tick(input logic ign, en, input logic [31:0] err, input logic batt);
    tick_t t;
    t.ign = ign;
    t.en = en;
    t.err = err;
    t.batt = batt;
    pending_ticks.push_back(t);
  endtask

  // mostly steady ignition and enable with short off spells, sparse errors
  task automatic add_random(input int unsigned n);
    int unsigned r;
    logic [31:0] err;
    logic        ign;
    logic        en;
    repeat (n) begin
      if (gen_ign) begin
        if ($urandom_range(99) < 4) gen_ign = 1'b0;
      end else if ($urandom_range(99) < 40) begin
        gen_ign = 1'b1;
      end
      if ($urandom_range(99) < 8) gen_en = !gen_en;
      ign = gen_ign;
      en = gen_en;
      if ($urandom_range(99) < 3) begin
        ign = 1'($urandom());
        en = 1'($urandom());
      end
      r = $urandom_range(99);
      if (r < 62)      err = '0;
      else if (r < 70) err = recov_m & $urandom();
      else if (r < 74) err = release_m & $urandom();
      else if (r < 78) err = fatal_m & $urandom();
      else if (r < 84) err = busoff_m;
      else if (r < 89) err = linkto_m;
      else if (r < 92) err = busoff_m & $urandom();
      else if (r < 99) err = $urandom();
      else             err = '1;
      add_tick(ign, en, err, $urandom_range(99) < 2);
    end
  endtask

  // block idle: nothing queued, nothing in flight, then extra idle slack
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_ch.valid || status_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // input word driver
  always @(posedge clk_i) begin : tick_driver
    tick_t nxt;
    tick_t sent;
    logic  took;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        sent.ign = in_ch.ignition_on;
        sent.en = in_ch.enable_request;
        sent.err = in_ch.error_status;
        sent.batt = in_ch.battery_disconnected;
        status_due.push_back(step_supervisor(sent));
        words_sent++;
      end
      if (!in_ch.valid || took) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_ticks.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.ignition_on <= nxt.ign;
          in_ch.enable_request <= nxt.en;
          in_ch.error_status <= nxt.err;
          in_ch.battery_disconnected <= nxt.batt;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result word monitor and checker
  always @(posedge clk_i) begin : status_monitor
    status_t     got;
    status_t     want;
    logic [6:0]  gf;
    logic [6:0]  wf;
    int          i;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.mode = out_ch.mode;
        got.flags = {out_ch.ready_flag, out_ch.run_flag, out_ch.regulator_init,
                     out_ch.pwm_enable, out_ch.derate_tick, out_ch.latch_release,
                     out_ch.clear_fatal_errors};
        if (status_due.size() == 0) begin
          note_mismatch("result word with no expected status");
        end else begin
          want = status_due.pop_front();
          mode_seen[want.mode]++;
          if (got.mode !== want.mode)
            note_mismatch($sformatf("result %0d mode got %0d want %0d",
                                    results_seen, got.mode, want.mode));
          gf = got.flags;
          wf = want.flags;
          for (i = 0; i < 7; i++)
            if (gf[6-i] !== wf[6-i])
              note_mismatch($sformatf("result %0d %s got %b want %b", results_seen,
                                      flag_name[i], gf[6-i], wf[6-i]));
          results_seen++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : sequencer
    int unsigned p;
    int unsigned drain_cnt;
    in_ch.valid = 1'b0;
    in_ch.ignition_on = 1'b0;
    in_ch.enable_request = 1'b0;
    in_ch.error_status = '0;
    in_ch.battery_disconnected = 1'b0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    src_idle_pct = 34;
    snk_idle_pct = 86;

    // directed walk through every mode and the quirks
    write_all(32'h0000_00F0, 32'h0000_0F00, 32'h0000_0100, 32'h0003_0000,
              32'h00C0_0000, 16'd1, 16'd1, 16'd2);
    add_tick(1'b0, 1'b0, 32'h0, 1'b0);          // init ignores ignition
    add_tick(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0);  // still counting
    add_tick(1'b0, 1'b0, 32'h0, 1'b0);          // ready flag set, ignition off to latch
    add_tick(1'b0, 1'b0, 32'h0, 1'b0);
    add_tick(1'b1, 1'b0, 32'h0, 1'b0);          // latch back to init, clear pulse
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);          // ready
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);          // run-check, regulator init
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);
    add_tick(1'b1, 1'b0, 32'h0000_0100, 1'b0);  // enable drop beats recoverable fault
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);          // run, pwm on
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);          // derate
    add_tick(1'b1, 1'b1, 32'h0003_0000, 1'b0);  // all bus-off bits
    add_tick(1'b1, 1'b1, 32'h0, 1'b1);          // battery holds recoverable fault
    add_tick(1'b1, 1'b1, 32'h0000_0100, 1'b0);  // release bit holds it
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);          // back to init
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);
    add_tick(1'b1, 1'b1, 32'h0000_0010, 1'b0);  // fatal
    add_tick(1'b1, 1'b1, 32'h0, 1'b0);
    add_tick(1'b0, 1'b0, 32'h0, 1'b0);          // fault to latch
    add_tick(1'b0, 1'b0, 32'h0, 1'b0);
    add_tick(1'b0, 1'b0, 32'h0, 1'b0);
    add_tick(1'b1, 1'b0, 32'h0, 1'b0);          // hold reached, release

    // random phases, register set changed only while idle
    for (p = 1; p <= 9; p++) begin
      wait_drained();
      if (p == 4) begin
        src_idle_pct = 86;
        snk_idle_pct = 34;
      end
      if (p == 7) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      setup_phase(p);
      if (p == 5) begin
        // sender holds off until every result is back
        add_random(60);
        wait_drained();
        add_random(60);
      end else begin
        add_random(120);
      end
    end

    // drain and settle
    while (pending_ticks.size() != 0 || in_ch.valid) @(posedge clk_i);
    drain_cnt = 0;
    while (status_due.size() != 0 && drain_cnt < 2000) begin
      @(posedge clk_i);
      drain_cnt++;
    end
    repeat (8) @(posedge clk_i);
    if (status_due.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", status_due.size()));

    $display("%0d words sent under %0d register settings, %0d results checked",
             words_sent, settings_cnt, results_seen);
    $display("results per mode init..latch: %0d %0d %0d %0d %0d %0d %0d %0d",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
             mode_seen[4], mode_seen[5], mode_seen[6], mode_seen[7]);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- converter_supervisor_fsm_unit.f -----
hw/rtl/cfsm_pkg.sv
hw/rtl/cfsm_in_if.sv
hw/rtl/cfsm_out_if.sv
hw/rtl/cfsm_cfg_regs.sv
hw/rtl/cfsm_step.sv
hw/rtl/converter_supervisor_fsm_unit.sv
hw/rtl/cfsm_checker.sv
tb/sv/testbench.sv
